>>> rtl/cnnp_pkg.sv
// Shared types and constants for the cellular noise nearest point core.
`default_nettype none
package cnnp_pkg;

    localparam logic [31:0] HASH_BASIS = 32'd2166136261;
    localparam logic [31:0] HASH_PRIME = 32'd16777619;
    localparam logic [31:0] LCG_MUL    = 32'd1103515245;
    localparam logic [31:0] LCG_ADD    = 32'd12345;
    localparam logic [31:0] SEED_RESET = 32'd12312;

    localparam logic [1:0] REG_SEED   = 2'd0;
    localparam logic [1:0] REG_DIMS   = 2'd1;
    localparam logic [1:0] REG_METRIC = 2'd2;

    localparam logic [1:0] METRIC_EUCLID = 2'd0;
    localparam logic [1:0] METRIC_MANH   = 2'd1;
    localparam logic [1:0] METRIC_CHEB   = 2'd2;

    typedef logic [31:0] limit_array_t [8];
    localparam limit_array_t POISSON_LIMITS = '{
        32'd393325350, 32'd1022645910, 32'd1861739990, 32'd2700834071,
        32'd3372109335, 32'd3819626178, 32'd4075350088, 32'd4203212043
    };

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CELL,
        ST_HASH,
        ST_LCG0,
        ST_COUNT,
        ST_LCG,
        ST_DIFF,
        ST_ACC,
        ST_POINT,
        ST_SQRT,
        ST_SCALE
    } state_t;

endpackage
`default_nettype wire

>>> rtl/cellular_noise_nearest_point_core.sv
// Top level of the Worley F1 cellular noise core with one shared multiplier.
`default_nettype none
// One sample point in, one F1 distance out. A small sequencer walks the 3, 9
// or 27 neighbor cells in turn; every hash step, LCG step and square of an axis
// difference goes through one shared 32x32 multiplier, one product per cycle.
// A cell holds 1 to 9 points, each visited axis by axis, and the Euclidean
// metric ends with a square root. The input is not ready while an item is in
// work; a finished result waits in the output register while the next request
// is taken, and a new result stalls only while the previous one is still unread.
module cellular_noise_nearest_point_core #(
    parameter int FRACTION_BITS       = 16,
    parameter int MAX_POINTS_PER_CELL = 9
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [95:0] s_axis_tdata,   // coord_x, coord_y, coord_z
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [23:0]      m_axis_tdata,   // noise_value, zero fill
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [31:0] cfg_data
);
    localparam int FB = FRACTION_BITS;
    localparam int CB = 32 - FB;
    // three squared axis differences below 2^(FB+1) each
    localparam int AW = 2 * FB + 4;
    localparam int RW = FB + 2;

    cnnp_pkg::state_t state_reg, state_next;

    logic [31:0] seed_reg;
    logic [1:0]  dims_reg;
    logic [1:0]  metric_reg;

    logic signed [31:0] pos_reg [3];
    logic [31:0] base_reg [3];
    logic [1:0]  dcfg_reg;     // effective dims 1..3
    logic [1:0]  mcfg_reg;
    logic [1:0]  off_reg [3];  // 0..2 per axis
    logic [31:0] cell_reg [3];
    logic [31:0] seed_sq_reg;
    logic [31:0] rnd_reg;
    logic [1:0]  hstep_reg;
    logic [3:0]  npts_reg;
    logic [3:0]  pidx_reg;
    logic [1:0]  axis_reg;
    logic [32:0] ad_reg;
    logic [AW-1:0] acc_reg;
    logic [AW-1:0] best_reg;
    logic [AW-1:0] rem_reg;
    logic [RW-1:0] root_reg;
    logic [4:0]  sq_reg;
    logic [16:0] out_reg;
    logic        out_valid_reg;

    // output slot is free for a new result this cycle
    logic out_free;
    assign out_free = !out_valid_reg || m_axis_tready;

    // shared multiplier
    logic [31:0] mul_a, mul_b;
    logic [63:0] mul_p;
    assign mul_p = mul_a * mul_b;

    logic [31:0] hash_in;
    always_comb
    begin
        hash_in = seed_reg;
        case (hstep_reg)
            2'd0: hash_in = cell_reg[0];
            2'd1: hash_in = (dcfg_reg == 2'd1) ? seed_reg : cell_reg[1];
            2'd2: hash_in = (dcfg_reg == 2'd1) ? seed_sq_reg
                          : (dcfg_reg == 2'd2) ? seed_reg
                          : cell_reg[2] + seed_reg;
            default: hash_in = seed_reg;
        endcase
    end

    logic [4:0] cnt_next;
    always_comb
    begin
        cnt_next = 5'd1;
        for (int i = 0; i < 8; i++)
        begin
            if (rnd_reg >= cnnp_pkg::POISSON_LIMITS[i])
            begin
                cnt_next = cnt_next + 5'd1;
            end
        end
        if (cnt_next > 5'(MAX_POINTS_PER_CELL))
        begin
            cnt_next = 5'(MAX_POINTS_PER_CELL);
        end
    end

    logic [31:0] ax_cell;
    logic signed [31:0] ax_pos;
    assign ax_cell = cell_reg[axis_reg];
    assign ax_pos  = pos_reg[axis_reg];

    // feature coordinate minus sample, at 33+FB bits to hold any difference
    logic signed [32+FB:0] diff;
    assign diff = $signed({ax_cell, {FB{1'b0}}})
                + $signed({1'b0, {(32){1'b0}}, rnd_reg[31:CB]})
                - (32+FB+1)'(ax_pos);
    logic [32+FB:0] diff_abs;
    assign diff_abs = diff[32+FB] ? (32+FB+1)'(-diff) : diff;

    logic last_cell;
    always_comb
    begin
        last_cell = (off_reg[0] == 2'd2);
        if (dcfg_reg >= 2'd2) last_cell = last_cell && off_reg[1] == 2'd2;
        if (dcfg_reg == 2'd3) last_cell = last_cell && off_reg[2] == 2'd2;
    end

    logic [AW-1:0] sq_trial;
    assign sq_trial = {root_reg, 2'b01} << (2 * sq_reg);

    always_comb
    begin
        mul_a = 32'd0;
        mul_b = 32'd0;
        case (state_reg)
            cnnp_pkg::ST_CELL:
            begin
                mul_a = seed_reg;
                mul_b = seed_reg;
            end
            cnnp_pkg::ST_HASH:
            begin
                mul_a = rnd_reg ^ hash_in;
                mul_b = cnnp_pkg::HASH_PRIME;
            end
            cnnp_pkg::ST_LCG0, cnnp_pkg::ST_LCG:
            begin
                mul_a = rnd_reg;
                mul_b = cnnp_pkg::LCG_MUL;
            end
            cnnp_pkg::ST_ACC:
            begin
                mul_a = ad_reg[31:0];
                mul_b = ad_reg[31:0];
            end
            default:
            begin
                mul_a = 32'd0;
                mul_b = 32'd0;
            end
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            cnnp_pkg::ST_IDLE:  if (s_axis_tvalid && s_axis_tready) state_next = cnnp_pkg::ST_CELL;
            cnnp_pkg::ST_CELL:  state_next = cnnp_pkg::ST_HASH;
            cnnp_pkg::ST_HASH:  if (hstep_reg == 2'd3) state_next = cnnp_pkg::ST_LCG0;
            cnnp_pkg::ST_LCG0:  state_next = cnnp_pkg::ST_COUNT;
            cnnp_pkg::ST_COUNT: state_next = cnnp_pkg::ST_LCG;
            cnnp_pkg::ST_LCG:   state_next = cnnp_pkg::ST_DIFF;
            cnnp_pkg::ST_DIFF:  state_next = cnnp_pkg::ST_ACC;
            cnnp_pkg::ST_ACC:
            begin
                if (axis_reg + 2'd1 < dcfg_reg) state_next = cnnp_pkg::ST_LCG;
                else                            state_next = cnnp_pkg::ST_POINT;
            end
            cnnp_pkg::ST_POINT:
            begin
                if (pidx_reg + 4'd1 < npts_reg) state_next = cnnp_pkg::ST_LCG;
                else if (!last_cell)            state_next = cnnp_pkg::ST_CELL;
                else if (mcfg_reg == cnnp_pkg::METRIC_EUCLID) state_next = cnnp_pkg::ST_SQRT;
                else                            state_next = cnnp_pkg::ST_SCALE;
            end
            cnnp_pkg::ST_SQRT:  if (sq_reg == 5'd0) state_next = cnnp_pkg::ST_SCALE;
            cnnp_pkg::ST_SCALE: if (out_free) state_next = cnnp_pkg::ST_IDLE;
            default:            state_next = cnnp_pkg::ST_IDLE;
        endcase
    end

    always_comb
    begin
        s_axis_tready = (state_reg == cnnp_pkg::ST_IDLE);
        cfg_ready     = (state_reg == cnnp_pkg::ST_IDLE);
        m_axis_tvalid = out_valid_reg;
        m_axis_tdata  = {7'd0, out_reg};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= cnnp_pkg::ST_IDLE;
            seed_reg      <= cnnp_pkg::SEED_RESET;
            dims_reg      <= 2'd2;
            metric_reg    <= cnnp_pkg::METRIC_EUCLID;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    cnnp_pkg::REG_SEED:   seed_reg   <= cfg_data;
                    cnnp_pkg::REG_DIMS:   dims_reg   <= cfg_data[1:0];
                    cnnp_pkg::REG_METRIC: metric_reg <= cfg_data[1:0];
                    default: ;
                endcase
            end
            if (state_reg == cnnp_pkg::ST_SCALE && out_free) out_valid_reg <= 1'b1;
            else if (m_axis_tvalid && m_axis_tready)         out_valid_reg <= 1'b0;
        end
    end

    logic [AW-1:0] dist_fin;
    always_comb
    begin
        dist_fin = (mcfg_reg == cnnp_pkg::METRIC_EUCLID) ? AW'(root_reg) : best_reg;
        if (dist_fin > (AW'(1) << FB)) dist_fin = AW'(1) << FB;
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            cnnp_pkg::ST_IDLE:
            begin
                pos_reg[0] <= s_axis_tdata[31:0];
                pos_reg[1] <= s_axis_tdata[63:32];
                pos_reg[2] <= s_axis_tdata[95:64];
                base_reg[0] <= 32'(($signed(s_axis_tdata[31:0])) >>> FB);
                base_reg[1] <= 32'(($signed(s_axis_tdata[63:32])) >>> FB);
                base_reg[2] <= 32'(($signed(s_axis_tdata[95:64])) >>> FB);
                dcfg_reg <= (dims_reg == 2'd0) ? 2'd1 : dims_reg;
                mcfg_reg <= (metric_reg == 2'd3) ? cnnp_pkg::METRIC_EUCLID : metric_reg;
                off_reg[0] <= 2'd0;
                off_reg[1] <= 2'd0;
                off_reg[2] <= 2'd0;
                best_reg <= '1;
            end
            cnnp_pkg::ST_CELL:
            begin
                for (int a = 0; a < 3; a++)
                begin
                    cell_reg[a] <= base_reg[a] + 32'(off_reg[a]) - 32'd1;
                end
                seed_sq_reg <= mul_p[31:0];
                rnd_reg     <= cnnp_pkg::HASH_BASIS;
                hstep_reg   <= 2'd0;
            end
            cnnp_pkg::ST_HASH:
            begin
                if (hstep_reg != 2'd3)
                begin
                    // fold one word per cycle through the shared multiplier
                    rnd_reg <= mul_p[31:0];
                end
                hstep_reg <= hstep_reg + 2'd1;
            end
            cnnp_pkg::ST_LCG0:
            begin
                rnd_reg <= mul_p[31:0] + cnnp_pkg::LCG_ADD;
            end
            cnnp_pkg::ST_COUNT:
            begin
                npts_reg <= cnt_next[3:0];
                pidx_reg <= 4'd0;
                axis_reg <= 2'd0;
                acc_reg  <= '0;
            end
            cnnp_pkg::ST_LCG:
            begin
                rnd_reg <= mul_p[31:0] + cnnp_pkg::LCG_ADD;
            end
            cnnp_pkg::ST_DIFF:
            begin
                ad_reg <= 33'(diff_abs);
            end
            cnnp_pkg::ST_ACC:
            begin
                if (mcfg_reg == cnnp_pkg::METRIC_MANH)
                    acc_reg <= acc_reg + AW'(ad_reg);
                else if (mcfg_reg == cnnp_pkg::METRIC_CHEB)
                begin
                    if (AW'(ad_reg) > acc_reg) acc_reg <= AW'(ad_reg);
                end
                else
                    acc_reg <= acc_reg + AW'(mul_p);
                axis_reg <= axis_reg + 2'd1;
            end
            cnnp_pkg::ST_POINT:
            begin
                if (acc_reg < best_reg) best_reg <= acc_reg;
                acc_reg  <= '0;
                axis_reg <= 2'd0;
                pidx_reg <= pidx_reg + 4'd1;
                if (pidx_reg + 4'd1 >= npts_reg)
                begin
                    // advance the cell offsets, last axis fastest
                    if (off_reg[dcfg_reg - 2'd1] != 2'd2)
                        off_reg[dcfg_reg - 2'd1] <= off_reg[dcfg_reg - 2'd1] + 2'd1;
                    else
                    begin
                        off_reg[dcfg_reg - 2'd1] <= 2'd0;
                        if (dcfg_reg >= 2'd2 && off_reg[dcfg_reg - 2'd2] != 2'd2)
                            off_reg[dcfg_reg - 2'd2] <= off_reg[dcfg_reg - 2'd2] + 2'd1;
                        else if (dcfg_reg >= 2'd2)
                        begin
                            off_reg[dcfg_reg - 2'd2] <= 2'd0;
                            if (dcfg_reg == 2'd3) off_reg[0] <= off_reg[0] + 2'd1;
                        end
                    end
                end
                rem_reg  <= (acc_reg < best_reg) ? acc_reg : best_reg;
                root_reg <= '0;
                sq_reg   <= 5'(RW - 1);
            end
            cnnp_pkg::ST_SQRT:
            begin
                // restoring square root, one result bit per cycle
                if (rem_reg >= sq_trial)
                begin
                    rem_reg  <= rem_reg - sq_trial;
                    root_reg <= {root_reg[RW-2:0], 1'b1};
                end
                else
                begin
                    root_reg <= {root_reg[RW-2:0], 1'b0};
                end
                sq_reg <= sq_reg - 5'd1;
            end
            cnnp_pkg::ST_SCALE:
            begin
                // hold until the previous result has left the output register
                if (out_free)
                begin
                    if (FB >= 16) out_reg <= 17'(dist_fin >> (FB - 16));
                    else          out_reg <= 17'(dist_fin << (16 - FB));
                end
            end
            default: ;
        endcase
    end

endmodule
`default_nettype wire
